[hdl/chs_pkg.sv]
// Shared types and constants for the disk address translator.
package chs_pkg;

    localparam int unsigned LbaW = 32;
    localparam int unsigned CylW = 16;
    localparam int unsigned HeadW = 4;
    localparam int unsigned SecW = 8;
    localparam int unsigned HeadCntW = 5;
    localparam int unsigned DivisorW = 12;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [LbaW-1:0] MAX_CHS_CAPACITY = 32'd16514064;
    localparam logic [CylW-1:0] CYL_LIMIT = 16'hFFFF;

    localparam logic [1:0] ACT_SET_GEO = 2'd0;
    localparam logic [1:0] ACT_CHS2LBA = 2'd1;
    localparam logic [1:0] ACT_LBA2CHS = 2'd2;

    localparam logic [1:0] STS_OK = 2'd0;
    localparam logic [1:0] STS_REJECT = 2'd1;
    localparam logic [1:0] STS_UNSET = 2'd2;
    localparam logic [1:0] STS_OVERFLOW = 2'd3;

    localparam logic [CfgIdxW-1:0] CFG_PHYS_HEADS = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PHYS_SECTORS = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [CylW-1:0]  cyl_in;
        logic [HeadW-1:0] head_in;
        logic [SecW-1:0]  sector_in;
        logic [LbaW-1:0]  lba_in;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [LbaW-1:0]  lba_out;
        logic [CylW-1:0]  cyl_out;
        logic [HeadW-1:0] head_out;
        logic [SecW-1:0]  sector_out;
        logic             accessible;
    } t_rsp;

    typedef struct packed {
        logic                start;
        logic [LbaW-1:0]     dividend;
        logic [DivisorW-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic                done;
        logic [LbaW-1:0]     quotient;
        logic [DivisorW-1:0] remainder;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_H,
        ST_MUL_S,
        ST_DIV_GEO,
        ST_DIV_S,
        ST_DIV_H
    } t_state;

endpackage

[hdl/chs_div.sv]
// Radix-2 restoring divider producing one quotient bit per cycle.
module chs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chs_pkg::t_div_cmd i_cmd,
    output chs_pkg::t_div_rsp o_rsp
);

    localparam int unsigned LbaW = chs_pkg::LbaW;
    localparam int unsigned DvW = chs_pkg::DivisorW;
    localparam int unsigned CntW = $clog2(LbaW);

    logic [LbaW-1:0] r_quo;
    logic [DvW-1:0]  r_rem;
    logic [DvW-1:0]  r_dvs;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [DvW:0]   shifted;
    logic [DvW+1:0] diff;

    assign shifted = {r_rem, r_quo[LbaW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && !r_busy) begin
            r_quo <= i_cmd.dividend;
            r_dvs <= i_cmd.divisor;
            r_rem <= '0;
            r_cnt <= CntW'(LbaW - 1);
        end else if (r_busy) begin
            // A set borrow bit means the trial subtraction went negative.
            if (diff[DvW+1]) begin
                r_rem <= shifted[DvW-1:0];
                r_quo <= {r_quo[LbaW-2:0], 1'b0};
            end else begin
                r_rem <= diff[DvW-1:0];
                r_quo <= {r_quo[LbaW-2:0], 1'b1};
            end
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

[hdl/chs_lba_address_translator.sv]
// Disk address translator: stored geometry, CHS to LBA and LBA to CHS conversion.
// Set geometry takes one divider pass of 32 shift steps; LBA to CHS takes two such passes
// (by sectors, then by heads); CHS to LBA takes 5 plus 8 shift-add steps.
// A rejected geometry or an unset geometry answers from idle without raising o_busy.
// One request at a time: i_start is taken only while idle; o_busy drops as o_done rises.
// Synchronous active-low reset: limits 16 heads, 63 sectors, zero capacity; no geometry.
module chs_lba_address_translator #(
    parameter logic [chs_pkg::LbaW-1:0] MAX_CHS_CAPACITY = chs_pkg::MAX_CHS_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  chs_pkg::t_req                 i_req,
    output logic                          o_done,
    output chs_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [chs_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [chs_pkg::LbaW-1:0]      i_cfg_data
);

    localparam int unsigned LbaW = chs_pkg::LbaW;
    localparam int unsigned CylW = chs_pkg::CylW;
    localparam int unsigned HeadW = chs_pkg::HeadW;
    localparam int unsigned SecW = chs_pkg::SecW;
    localparam int unsigned HcW = chs_pkg::HeadCntW;
    localparam int unsigned DvW = chs_pkg::DivisorW;

    // Configuration registers and the stored logical geometry.
    logic [HcW-1:0]  r_phys_heads;
    logic [SecW-1:0] r_phys_secs;
    logic [LbaW-1:0] r_capacity;
    logic [CylW-1:0] r_log_cyls, n_log_cyls;
    logic [HcW-1:0]  r_log_heads, n_log_heads;
    logic [SecW-1:0] r_log_secs, n_log_secs;

    // Sequencer and datapath registers.
    chs_pkg::t_state r_state, n_state;
    chs_pkg::t_req   r_req, n_req;
    chs_pkg::t_rsp   r_rsp, n_rsp;
    logic            r_done, n_done;
    logic [LbaW-1:0] r_acc, n_acc;
    logic [LbaW-1:0] r_mcand, n_mcand;
    logic [SecW-1:0] r_mplier, n_mplier;
    logic [2:0]      r_cnt, n_cnt;
    logic [SecW-1:0] r_sec_rem, n_sec_rem;

    chs_pkg::t_div_cmd div_cmd;
    chs_pkg::t_div_rsp div_rsp;

    logic [LbaW-1:0] mult_sum;
    logic [LbaW-1:0] cap_clamped;
    logic [HcW-1:0]  head_cnt;
    logic [DvW-1:0]  geo_divisor;
    logic            geo_reject;

    chs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_rsp   (div_rsp)
    );

    // The config port never stalls; the user must write it only while idle, which is not enforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phys_heads <= HcW'(16);
            r_phys_secs  <= SecW'(63);
            r_capacity   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                chs_pkg::CFG_PHYS_HEADS:   r_phys_heads <= i_cfg_data[HcW-1:0];
                chs_pkg::CFG_PHYS_SECTORS: r_phys_secs  <= i_cfg_data[SecW-1:0];
                chs_pkg::CFG_CAPACITY:     r_capacity   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Multiplication is done most significant multiplier bit first: double the
    // accumulator and add the multiplicand when the current bit is set.
    assign mult_sum = {r_acc[LbaW-2:0], 1'b0} + (r_mplier[SecW-1] ? r_mcand : '0);

    // Set geometry operands: clamped capacity, plus divisor and checks from the request being accepted.
    assign cap_clamped = (r_capacity > MAX_CHS_CAPACITY) ? MAX_CHS_CAPACITY : r_capacity;
    assign head_cnt    = {1'b0, i_req.head_in} + HcW'(1);
    assign geo_divisor = DvW'(head_cnt) * DvW'(i_req.sector_in);
    assign geo_reject  = ({1'b0, i_req.head_in} > r_phys_heads) ||
                         (i_req.sector_in > r_phys_secs) || (i_req.sector_in == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chs_pkg::ST_IDLE;
            r_done      <= 1'b0;
            r_log_cyls  <= '0;
            r_log_heads <= '0;
            r_log_secs  <= '0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_log_cyls  <= n_log_cyls;
            r_log_heads <= n_log_heads;
            r_log_secs  <= n_log_secs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rsp     <= n_rsp;
        r_acc     <= n_acc;
        r_mcand   <= n_mcand;
        r_mplier  <= n_mplier;
        r_cnt     <= n_cnt;
        r_sec_rem <= n_sec_rem;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_rsp       = r_rsp;
        n_done      = 1'b0;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_cnt       = r_cnt;
        n_sec_rem   = r_sec_rem;
        n_log_cyls  = r_log_cyls;
        n_log_heads = r_log_heads;
        n_log_secs  = r_log_secs;
        div_cmd     = '0;

        unique case (r_state)
            chs_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    case (i_req.action)
                        chs_pkg::ACT_SET_GEO: begin
                            if (geo_reject) begin
                                n_rsp        = '0;
                                n_rsp.status = chs_pkg::STS_REJECT;
                                n_done       = 1'b1;
                            end else begin
                                div_cmd.start    = 1'b1;
                                div_cmd.dividend = cap_clamped;
                                div_cmd.divisor  = geo_divisor;
                                n_state          = chs_pkg::ST_DIV_GEO;
                            end
                        end
                        chs_pkg::ACT_CHS2LBA: begin
                            // First pass forms cylinder times head count.
                            n_mcand  = LbaW'(i_req.cyl_in);
                            n_acc    = '0;
                            n_mplier = {r_log_heads, {(SecW-HcW){1'b0}}};
                            n_cnt    = 3'(HcW - 1);
                            n_state  = chs_pkg::ST_MUL_H;
                        end
                        chs_pkg::ACT_LBA2CHS: begin
                            if ((r_log_secs == '0) || (r_log_heads == '0)) begin
                                n_rsp            = '0;
                                n_rsp.status     = chs_pkg::STS_UNSET;
                                n_rsp.lba_out    = i_req.lba_in;
                                n_rsp.accessible = i_req.lba_in < r_capacity;
                                n_done           = 1'b1;
                            end else begin
                                div_cmd.start    = 1'b1;
                                div_cmd.dividend = i_req.lba_in;
                                div_cmd.divisor  = DvW'(r_log_secs);
                                n_state          = chs_pkg::ST_DIV_S;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            chs_pkg::ST_MUL_H: begin
                n_acc    = mult_sum;
                n_mplier = {r_mplier[SecW-2:0], 1'b0};
                n_cnt    = r_cnt - 3'd1;
                if (r_cnt == '0) begin
                    // Add the head, then multiply the sum by sectors per track.
                    n_mcand  = mult_sum + LbaW'(r_req.head_in);
                    n_acc    = '0;
                    n_mplier = r_log_secs;
                    n_cnt    = 3'(SecW - 1);
                    n_state  = chs_pkg::ST_MUL_S;
                end
            end
            chs_pkg::ST_MUL_S: begin
                n_acc    = mult_sum;
                n_mplier = {r_mplier[SecW-2:0], 1'b0};
                n_cnt    = r_cnt - 3'd1;
                if (r_cnt == '0) begin
                    n_rsp.status     = chs_pkg::STS_OK;
                    n_rsp.lba_out    = mult_sum + LbaW'(r_req.sector_in);
                    n_rsp.cyl_out    = r_req.cyl_in;
                    n_rsp.head_out   = r_req.head_in;
                    n_rsp.sector_out = r_req.sector_in;
                    n_rsp.accessible = (mult_sum + LbaW'(r_req.sector_in)) < r_capacity;
                    n_done           = 1'b1;
                    n_state          = chs_pkg::ST_IDLE;
                end
            end
            chs_pkg::ST_DIV_GEO: begin
                if (div_rsp.done) begin
                    n_log_cyls  = (div_rsp.quotient[LbaW-1:CylW] != '0) ?
                                  chs_pkg::CYL_LIMIT : div_rsp.quotient[CylW-1:0];
                    n_log_heads = {1'b0, r_req.head_in} + HcW'(1);
                    n_log_secs  = r_req.sector_in;
                    n_rsp            = '0;
                    n_rsp.status     = chs_pkg::STS_OK;
                    n_rsp.cyl_out    = n_log_cyls;
                    n_rsp.head_out   = r_req.head_in;
                    n_rsp.sector_out = r_req.sector_in;
                    n_done           = 1'b1;
                    n_state          = chs_pkg::ST_IDLE;
                end
            end
            chs_pkg::ST_DIV_S: begin
                if (div_rsp.done) begin
                    // The remainder is the sector; the quotient is split by head count next.
                    n_sec_rem        = div_rsp.remainder[SecW-1:0];
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = div_rsp.quotient;
                    div_cmd.divisor  = DvW'(r_log_heads);
                    n_state          = chs_pkg::ST_DIV_H;
                end
            end
            chs_pkg::ST_DIV_H: begin
                if (div_rsp.done) begin
                    n_rsp.status     = (div_rsp.quotient[LbaW-1:CylW] != '0) ?
                                       chs_pkg::STS_OVERFLOW : chs_pkg::STS_OK;
                    n_rsp.lba_out    = r_req.lba_in;
                    n_rsp.cyl_out    = div_rsp.quotient[CylW-1:0];
                    n_rsp.head_out   = div_rsp.remainder[HeadW-1:0];
                    n_rsp.sector_out = r_sec_rem;
                    n_rsp.accessible = r_req.lba_in < r_capacity;
                    n_done           = 1'b1;
                    n_state          = chs_pkg::ST_IDLE;
                end
            end
            default: n_state = chs_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != chs_pkg::ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
